/* hw/rtl/tsrr_pkg.sv */
// types, constants and codes for the thread slot round-robin scheduler
// no dependencies; imported by the interfaces and every module of the block

package tsrr_pkg;

  localparam int unsigned SlotCountDef  = 8;
  localparam int unsigned OpW           = 2;
  localparam int unsigned AddrW         = 64;
  localparam int unsigned StatusW       = 2;
  localparam int unsigned SlotW         = 3;
  localparam int unsigned SliceW        = 8;
  localparam int unsigned ApbAddrW      = 3;
  localparam int unsigned ApbDataW      = 32;
  localparam logic [SliceW-1:0] SliceResetVal = 8'd10;

  typedef enum logic [OpW-1:0] {
    OP_CREATE = 2'd0,
    OP_KILL   = 2'd1,
    OP_SWITCH = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_FREE    = 2'd0,
    ST_READY   = 2'd1,
    ST_RUNNING = 2'd2
  } slot_st_e;

  typedef enum logic [StatusW-1:0] {
    RES_OK       = 2'd0,
    RES_NO_FREE  = 2'd1,
    RES_NO_READY = 2'd2
  } res_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CREATE,
    S_SW_CUR,
    S_SWITCH,
    S_DEMOTE,
    S_LOAD,
    S_FETCH,
    S_FINISH
  } ctrl_st_e;

  typedef struct packed {
    logic     st_we;
    slot_st_e st_wdata;
    logic     addr_we;
  } tbl_cmd_t;

endpackage

/* hw/rtl/tsrr_ifs.sv */
// valid/ready channel interfaces for scheduler input and result items
// depends on tsrr_pkg

interface tsrr_in_if import tsrr_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [OpW-1:0]   opcode;
  logic [AddrW-1:0] entry_address;

  modport source(output valid, opcode, entry_address, input ready);
  modport sink(input valid, opcode, entry_address, output ready);
endinterface

interface tsrr_out_if import tsrr_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [StatusW-1:0] status;
  logic [SlotW-1:0]   slot_index;
  logic [SlotW-1:0]   current_index;
  logic [AddrW-1:0]   start_address;
  logic [SliceW-1:0]  slice_ticks;

  modport source(output valid, status, slot_index, current_index, start_address, slice_ticks,
                 input ready);
  modport sink(input valid, status, slot_index, current_index, start_address, slice_ticks,
               output ready);
endinterface

/* hw/rtl/thread_slot_round_robin_scheduler_unit.sv */
// top level of the thread slot round-robin scheduler: config register, sequencer, slot table
// depends on tsrr_pkg, tsrr_ifs, tsrr_table, tsrr_ctrl

// Each input item (create, kill, switch) yields one result item. The block takes one item
// at a time; a single slot pointer with a wrapping incrementer visits one slot per cycle and
// the status of that slot is compared against free or ready. Create does a lowest free slot
// search; switch reads the current slot, does a round-robin scan, then reads the registered
// entry address memory. The result sits in an output register, so a stalled result does not
// block the next item from being accepted; that next item then waits in its last state until
// the register frees.
// slice_length lives at byte address 0 of the APB port and resets to 10; write it only while
// the block is idle.

module thread_slot_round_robin_scheduler_unit import tsrr_pkg::*; #(
  parameter int unsigned SlotCount = SlotCountDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  tsrr_in_if.sink             in_i,
  tsrr_out_if.source          out_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready
);

  localparam int unsigned IdxW = $clog2(SlotCount);

  logic [SliceW-1:0] slice_q;
  logic [IdxW-1:0]   ptr, st_waddr;
  tbl_cmd_t          cmd;
  logic [AddrW-1:0]  entry, addr_rdata;
  slot_st_e          st_rdata;
  logic              slice_sel;

  assign pready    = 1'b1;
  assign slice_sel = (paddr[ApbAddrW-1] == 1'b0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slice_q <= SliceResetVal;
    end else if (psel && penable && pwrite && slice_sel) begin
      slice_q <= pwdata[SliceW-1:0];
    end
  end

  assign prdata = slice_sel ? ApbDataW'(slice_q) : '0;

  tsrr_ctrl #(
    .SlotCount(SlotCount)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .out_o       (out_o),
    .slice_len_i (slice_q),
    .ptr_o       (ptr),
    .st_waddr_o  (st_waddr),
    .cmd_o       (cmd),
    .entry_o     (entry),
    .st_rdata_i  (st_rdata),
    .addr_rdata_i(addr_rdata)
  );

  tsrr_table #(
    .SlotCount(SlotCount)
  ) u_table (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ptr_i       (ptr),
    .st_waddr_i  (st_waddr),
    .cmd_i       (cmd),
    .entry_i     (entry),
    .st_rdata_o  (st_rdata),
    .addr_rdata_o(addr_rdata)
  );

endmodule

/* hw/rtl/tsrr_table.sv */
// slot table: per-slot status flops and the entry address memory
// depends on tsrr_pkg

module tsrr_table import tsrr_pkg::*; #(
  parameter int unsigned SlotCount = SlotCountDef,
  localparam int unsigned IdxW = $clog2(SlotCount)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [IdxW-1:0]  ptr_i,
  input  logic [IdxW-1:0]  st_waddr_i,
  input  tbl_cmd_t         cmd_i,
  input  logic [AddrW-1:0] entry_i,
  output slot_st_e         st_rdata_o,
  output logic [AddrW-1:0] addr_rdata_o
);

  slot_st_e         st_q [SlotCount];
  logic [AddrW-1:0] mem [SlotCount];
  logic [AddrW-1:0] rdata_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SlotCount; i++) begin
        st_q[i] <= ST_FREE;
      end
    end else if (cmd_i.st_we) begin
      st_q[st_waddr_i] <= cmd_i.st_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.addr_we) begin
      mem[ptr_i] <= entry_i;
    end
    rdata_q <= mem[ptr_i];
  end

  assign st_rdata_o   = st_q[ptr_i];
  assign addr_rdata_o = rdata_q;

endmodule

/* hw/rtl/tsrr_ctrl.sv */
// sequencer: walks the slot pointer one slot a cycle and holds the result register
// depends on tsrr_pkg, tsrr_ifs

module tsrr_ctrl import tsrr_pkg::*; #(
  parameter int unsigned SlotCount = SlotCountDef,
  localparam int unsigned IdxW = $clog2(SlotCount)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  tsrr_in_if.sink           in_i,
  tsrr_out_if.source        out_o,
  input  logic [SliceW-1:0] slice_len_i,
  output logic [IdxW-1:0]   ptr_o,
  output logic [IdxW-1:0]   st_waddr_o,
  output tbl_cmd_t          cmd_o,
  output logic [AddrW-1:0]  entry_o,
  input  slot_st_e          st_rdata_i,
  input  logic [AddrW-1:0]  addr_rdata_i
);

  localparam logic [IdxW-1:0] LastIdx = IdxW'(SlotCount - 1);

  ctrl_st_e          state_q, state_d;
  logic [IdxW-1:0]   ptr_q, ptr_d, cur_q, cur_d, ptr_inc;
  logic              run_q, run_d;
  op_e               op_q, op_d;
  logic [AddrW-1:0]  entry_q, entry_d;
  res_e              res_st_q, res_st_d;
  logic [IdxW-1:0]   res_slot_q, res_slot_d;
  logic [AddrW-1:0]  res_addr_q, res_addr_d;
  logic [SliceW-1:0] res_slice_q, res_slice_d;
  logic              out_valid_q, out_valid_d;
  res_e              out_st_q, out_st_d;
  logic [SlotW-1:0]  out_slot_q, out_slot_d, out_cur_q, out_cur_d;
  logic [AddrW-1:0]  out_addr_q, out_addr_d;
  logic [SliceW-1:0] out_slice_q, out_slice_d;

  assign ptr_inc = (ptr_q == LastIdx) ? '0 : ptr_q + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cur_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cur_q       <= cur_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q       <= ptr_d;
    run_q       <= run_d;
    op_q        <= op_d;
    entry_q     <= entry_d;
    res_st_q    <= res_st_d;
    res_slot_q  <= res_slot_d;
    res_addr_q  <= res_addr_d;
    res_slice_q <= res_slice_d;
    out_st_q    <= out_st_d;
    out_slot_q  <= out_slot_d;
    out_cur_q   <= out_cur_d;
    out_addr_q  <= out_addr_d;
    out_slice_q <= out_slice_d;
  end

  always_comb begin
    state_d     = state_q;
    ptr_d       = ptr_q;
    cur_d       = cur_q;
    run_d       = run_q;
    op_d        = op_q;
    entry_d     = entry_q;
    res_st_d    = res_st_q;
    res_slot_d  = res_slot_q;
    res_addr_d  = res_addr_q;
    res_slice_d = res_slice_q;
    out_valid_d = out_valid_q;
    out_st_d    = out_st_q;
    out_slot_d  = out_slot_q;
    out_cur_d   = out_cur_q;
    out_addr_d  = out_addr_q;
    out_slice_d = out_slice_q;
    cmd_o       = '{st_we: 1'b0, st_wdata: ST_FREE, addr_we: 1'b0};
    st_waddr_o  = ptr_q;

    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          op_d        = op_e'(in_i.opcode);
          entry_d     = in_i.entry_address;
          res_st_d    = RES_OK;
          res_slot_d  = cur_q;
          res_addr_d  = '0;
          res_slice_d = '0;
          ptr_d       = cur_q;
          case (op_e'(in_i.opcode))
            OP_CREATE: begin
              ptr_d   = '0;
              state_d = S_CREATE;
            end
            OP_KILL:   state_d = S_LOAD;
            OP_SWITCH: state_d = S_SW_CUR;
            default:   state_d = S_FINISH;
          endcase
        end
      end
      S_CREATE: begin
        if (st_rdata_i == ST_FREE) begin
          cmd_o.st_we    = 1'b1;
          cmd_o.st_wdata = ST_READY;
          cmd_o.addr_we  = 1'b1;
          res_slot_d     = ptr_q;
          res_addr_d     = entry_q;
          state_d        = S_FINISH;
        end else if (ptr_q == LastIdx) begin
          res_st_d   = RES_NO_FREE;
          res_slot_d = '0;
          state_d    = S_FINISH;
        end else begin
          ptr_d = ptr_inc;
        end
      end
      S_SW_CUR: begin
        run_d   = (st_rdata_i == ST_RUNNING);
        ptr_d   = ptr_inc;
        state_d = S_SWITCH;
      end
      S_SWITCH: begin
        if (st_rdata_i == ST_READY) begin
          cmd_o.st_we    = 1'b1;
          cmd_o.st_wdata = ST_RUNNING;
          res_slot_d     = ptr_q;
          res_slice_d    = slice_len_i;
          state_d        = S_DEMOTE;
        end else if (ptr_inc == cur_q) begin
          if (run_q) begin
            ptr_d   = cur_q;
            state_d = S_LOAD;
          end else begin
            res_st_d = RES_NO_READY;
            state_d  = S_FINISH;
          end
        end else begin
          ptr_d = ptr_inc;
        end
      end
      S_DEMOTE: begin
        st_waddr_o     = cur_q;
        cmd_o.st_we    = run_q;
        cmd_o.st_wdata = ST_READY;
        cur_d          = ptr_q;
        state_d        = S_FETCH;
      end
      S_LOAD: begin
        cmd_o.st_we    = (op_q == OP_KILL);
        cmd_o.st_wdata = ST_FREE;
        state_d        = S_FETCH;
      end
      S_FETCH: begin
        res_addr_d = addr_rdata_i;
        state_d    = S_FINISH;
      end
      S_FINISH: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          out_st_d    = res_st_q;
          out_slot_d  = SlotW'(res_slot_q);
          out_cur_d   = SlotW'(cur_q);
          out_addr_d  = res_addr_q;
          out_slice_d = res_slice_q;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign in_i.ready          = (state_q == S_IDLE);
  assign out_o.valid         = out_valid_q;
  assign out_o.status        = out_st_q;
  assign out_o.slot_index    = out_slot_q;
  assign out_o.current_index = out_cur_q;
  assign out_o.start_address = out_addr_q;
  assign out_o.slice_ticks   = out_slice_q;
  assign ptr_o               = ptr_q;
  assign entry_o             = entry_q;

endmodule
